// File: rtl/core/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types and constants for the half/single float converter pipeline.
// ----------------------------------------------------------------------------
package hsfc_pkg;

    // function codes (code 3 is unused and answers zero)
    typedef enum logic [1:0] {
        FUNC_H2S = 2'd0,   // half to single
        FUNC_S2H = 2'd1,   // single to half
        FUNC_RT  = 2'd2    // single rounded to half, widened back
    } func_t;

    // single exponent thresholds for narrowing
    localparam logic [7:0] EXP_SUB_MIN  = 8'd102;  // below: signed zero
    localparam logic [7:0] EXP_NORM_MIN = 8'd113;  // from here: normal half
    localparam logic [7:0] EXP_OVF      = 8'd143;  // from here: infinity
    localparam logic [7:0] EXP_BIAS_DIF = 8'd112;  // single bias minus half bias
    localparam logic [7:0] EXP_SUB_BASE = 8'd126;  // shift = base - exponent
    localparam logic [7:0] EXP_ALL_ONE  = 8'hFF;
    localparam logic [4:0] SHIFT_NORM   = 5'd13;

    localparam logic [14:0] HALF_INF    = 15'h7C00;
    localparam logic [4:0]  HEXP_ALL_ONE = 5'h1F;

    // stage 1: classified narrowing operand
    typedef struct packed {
        func_t       func;
        logic [15:0] low_half;    // operand low bits for widening
        logic        fixed;       // result already known
        logic [15:0] fixed_half;
        logic        sign;
        logic [23:0] mant;        // mantissa with hidden bit
        logic [4:0]  shift;       // right shift into half mantissa
        logic [4:0]  hexp;        // half exponent, zero for subnormal
    } hsfc_s1_t;

    // stage 2: half-precision value chosen for the last stage
    typedef struct packed {
        func_t       func;
        logic [15:0] half;
    } hsfc_s2_t;

endpackage

// File: rtl/core/hsfc_narrow_classify.sv
// ----------------------------------------------------------------------------
// hsfc_narrow_classify
// Sorts a single into special, subnormal-half and normal-half cases.
// ----------------------------------------------------------------------------
module hsfc_narrow_classify (
    input  hsfc_pkg::func_t  func,
    input  logic [31:0]      operand_bits,
    output hsfc_pkg::hsfc_s1_t s1
);
    import hsfc_pkg::*;

    logic       sign;
    logic [7:0] ef;

    assign sign = operand_bits[31];
    assign ef   = operand_bits[30:23];

    always_comb
    begin
        s1.func       = func;
        s1.low_half   = operand_bits[15:0];
        s1.fixed      = 1'b0;
        s1.fixed_half = 16'd0;
        s1.sign       = sign;
        s1.mant       = {1'b1, operand_bits[22:0]};
        s1.shift      = SHIFT_NORM;
        s1.hexp       = 5'd0;
        if (ef == EXP_ALL_ONE)
        begin
            // inf/NaN: payload truncated to top ten bits
            s1.fixed      = 1'b1;
            s1.fixed_half = {sign, HEXP_ALL_ONE, operand_bits[22:13]};
        end
        else if (ef < EXP_SUB_MIN)
        begin
            // includes zero and single subnormals
            s1.fixed      = 1'b1;
            s1.fixed_half = {sign, 15'd0};
        end
        else if (ef >= EXP_OVF)
        begin
            s1.fixed      = 1'b1;
            s1.fixed_half = {sign, HALF_INF};
        end
        else if (ef < EXP_NORM_MIN)
        begin
            s1.shift = 5'(EXP_SUB_BASE - ef);
        end
        else
        begin
            s1.hexp = 5'(ef - EXP_BIAS_DIF);
        end
    end

endmodule

// File: rtl/core/hsfc_narrow_round.sv
// ----------------------------------------------------------------------------
// hsfc_narrow_round
// Aligns the mantissa and rounds to nearest even into a half pattern.
// ----------------------------------------------------------------------------
module hsfc_narrow_round (
    input  hsfc_pkg::hsfc_s1_t s1,
    output logic [15:0]        half
);
    import hsfc_pkg::*;

    logic [23:0] shifted;
    logic [4:0]  rb_pos;
    logic [23:0] sticky_mask;
    logic        rnd;
    logic        sticky;
    logic        inc;
    logic [14:0] mag;

    assign shifted     = s1.mant >> s1.shift;
    assign rb_pos      = s1.shift - 5'd1;
    assign rnd         = s1.mant[rb_pos];
    assign sticky_mask = (24'd1 << rb_pos) - 24'd1;
    assign sticky      = |(s1.mant & sticky_mask);
    assign inc         = rnd & (sticky | shifted[0]);
    // carry out of the mantissa lands in the exponent; 30/3FF rolls to inf
    assign mag         = {s1.hexp, shifted[9:0]} + {14'd0, inc};
    assign half        = s1.fixed ? s1.fixed_half : {s1.sign, mag};

endmodule

// File: rtl/core/hsfc_widen.sv
// ----------------------------------------------------------------------------
// hsfc_widen
// Exact half to single widening with subnormal normalization.
// ----------------------------------------------------------------------------
module hsfc_widen (
    input  logic [15:0] half,
    output logic [31:0] single
);
    import hsfc_pkg::*;

    logic       sign;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] lead;     // position of the leading one
    logic [3:0] k;        // shifts to reach the hidden bit
    logic [9:0] norm;

    assign sign = half[15];
    assign ex   = half[14:10];
    assign man  = half[9:0];

    always_comb
    begin
        lead = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
                lead = 4'(i);
        end
    end

    assign k    = 4'd10 - lead;
    assign norm = man << k;

    always_comb
    begin
        if (ex == 5'd0)
        begin
            if (man == 10'd0)
                single = {sign, 31'd0};
            else
                single = {sign, EXP_NORM_MIN - {4'd0, k}, norm, 13'd0};
        end
        else if (ex == HEXP_ALL_ONE)
            single = {sign, EXP_ALL_ONE, man, 13'd0};
        else
            single = {sign, {3'd0, ex} + EXP_BIAS_DIF, man, 13'd0};
    end

endmodule

// File: rtl/core/half_single_float_converter.sv
// ----------------------------------------------------------------------------
// half_single_float_converter
// Data path: s1_reg, then s2_reg, then out_reg, which drives m_tdata.
// Throughput: one transfer per cycle; three register stages with valid bits,
// stalls from m_tready back up through the stages without loss.
// Reset: rst_n asynchronous active low clears the stage valid bits only.
// ----------------------------------------------------------------------------
// Stage 1 classifies the single for narrowing, stage 2 aligns and rounds
// to a half (or passes the operand's low half for widening), stage 3 widens
// and selects the result by function code.
module half_single_float_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_bits
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] result_bits
);
    import hsfc_pkg::*;

    hsfc_s1_t    s1_next, s1_reg;
    hsfc_s2_t    s2_next, s2_reg;
    logic [31:0] out_next, out_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;
    logic [15:0] rounded;
    logic [31:0] widened;

    // a stage may load when it is empty or its contents move on
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = out_reg;

    // stage 1: classify
    hsfc_narrow_classify u_classify (
        .func         (func_t'(s_tuser)),
        .operand_bits (s_tdata),
        .s1           (s1_next)
    );

    // stage 2: round, or pick the operand half when widening only
    hsfc_narrow_round u_round (
        .s1   (s1_reg),
        .half (rounded)
    );

    always_comb
    begin
        s2_next.func = s1_reg.func;
        s2_next.half = (s1_reg.func == FUNC_H2S) ? s1_reg.low_half : rounded;
    end

    // stage 3: widen and select
    hsfc_widen u_widen (
        .half   (s2_reg.half),
        .single (widened)
    );

    always_comb
    begin
        case (s2_reg.func)
            FUNC_H2S: out_next = widened;
            FUNC_RT:  out_next = widened;
            FUNC_S2H: out_next = {16'd0, s2_reg.half};
            default:  out_next = 32'd0;
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= s_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (adv1 && s_tvalid)
            s1_reg <= s1_next;
        if (adv2 && v1_reg)
            s2_reg <= s2_next;
        if (adv3 && v2_reg)
            out_reg <= out_next;
    end

endmodule

// File: sim/tb_half_single_float_converter.sv
// ----------------------------------------------------------------------------
// tb_half_single_float_converter
// Self-checking bench for the binary16/binary32 converter.
// It drives a table of corner-case operands, then about 650 random ones.
// Every transfer is scored against the table result where known, else a bit-exact conversion model kept here.
// The sender and receiver back off at random in the first two of three idle phases.
// ----------------------------------------------------------------------------
module tb_half_single_float_converter;

    import hsfc_pkg::*;

    // code 3 has no operation behind it; the block answers zero
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int CLK_PERIOD       = 8;
    localparam int RANDOM_PER_PHASE = 217;
    localparam int DRAIN_CYCLES     = 8;     // pipeline depth plus margin
    localparam int MAX_REPORTS      = 10;
    localparam int NUM_DIRECTED     = 24;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;  // [31:0] operand_bits
    logic [1:0]  s_tuser  = 2'd0;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] result_bits

    // idle rates in percent, changed per phase by the stimulus process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // results still owed by the block, oldest first
    logic [31:0] expected_results[$];
    logic [31:0] oldest_result;

    int mismatch_count = 0;
    int results_seen   = 0;
    int func_count[4]  = '{default: 0};

    // one row of the corner-case table; result is used only when known is set
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] operand;
        logic        known;
        logic [31:0] result;
    } conv_case_t;

    conv_case_t directed_cases [NUM_DIRECTED] = '{
        // widening: zeros, subnormal edges, largest normal, infinity, NaN
        '{FUNC_H2S,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_H2S,    32'h0000_8000, 1'b1, 32'h8000_0000},
        '{FUNC_H2S,    32'h0000_0001, 1'b0, 32'd0},
        '{FUNC_H2S,    32'h0000_03FF, 1'b0, 32'd0},
        '{FUNC_H2S,    32'h0000_7BFF, 1'b0, 32'd0},
        '{FUNC_H2S,    32'h0000_7C00, 1'b1, 32'h7F80_0000},
        '{FUNC_H2S,    32'hABCD_FE01, 1'b0, 32'd0},   // upper half is ignored
        // narrowing: infinity, NaN payloads, single subnormals
        '{FUNC_S2H,    32'h7F80_0000, 1'b1, 32'h0000_7C00},
        '{FUNC_S2H,    32'h7F80_0001, 1'b1, 32'h0000_7C00}, // NaN loses its payload
        '{FUNC_S2H,    32'hFFFF_FFFF, 1'b0, 32'd0},
        '{FUNC_S2H,    32'h007F_FFFF, 1'b1, 32'h0000_0000},
        '{FUNC_S2H,    32'h8000_0001, 1'b1, 32'h0000_8000},
        // overflow and the carry past the largest finite half
        '{FUNC_S2H,    32'h4780_0000, 1'b1, 32'h0000_7C00},
        '{FUNC_S2H,    32'h477F_E000, 1'b1, 32'h0000_7BFF},
        '{FUNC_S2H,    32'h477F_F000, 1'b0, 32'd0},
        // ties to even, down then up
        '{FUNC_S2H,    32'h3F80_1000, 1'b0, 32'd0},
        '{FUNC_S2H,    32'h3F80_3000, 1'b0, 32'd0},
        // subnormal rounding up into the smallest normal half
        '{FUNC_S2H,    32'h387F_F000, 1'b0, 32'd0},
        // far too small: tie at the bottom, just over it, one binade below
        '{FUNC_S2H,    32'h3300_0000, 1'b0, 32'd0},
        '{FUNC_S2H,    32'h3300_0001, 1'b0, 32'd0},
        '{FUNC_S2H,    32'h3280_0000, 1'b1, 32'h0000_0000},
        // round trip, then the unused code
        '{FUNC_RT,     32'h3F80_3000, 1'b0, 32'd0},
        '{FUNC_RT,     32'hC77F_F000, 1'b0, 32'd0},
        '{FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000}
    };

    half_single_float_converter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Exact half to single widening; subnormals are normalized by shifting
    // the mantissa up to the hidden-bit position.
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic        sgn;
        logic [4:0]  hexp;
        logic [10:0] mant;
        logic [7:0]  sexp;
        sgn  = h[15];
        hexp = h[14:10];
        mant = {1'b0, h[9:0]};
        if (hexp == 5'd0)
        begin
            if (mant == 11'd0)
                return {sgn, 31'd0};
            sexp = 8'd113;
            while (!mant[10])
            begin
                mant = mant << 1;
                sexp = sexp - 8'd1;
            end
            return {sgn, sexp, mant[9:0], 13'd0};
        end
        if (hexp == 5'h1F)
            return {sgn, 8'hFF, h[9:0], 13'd0};
        return {sgn, {3'b000, hexp} + 8'd112, h[9:0], 13'd0};
    endfunction

    // Single to half narrowing, round to nearest even.
    function automatic logic [15:0] narrow_single(input logic [31:0] x);
        logic        sgn;
        logic [7:0]  sexp;
        logic [23:0] mant;
        logic [23:0] kept;
        logic [23:0] rem;
        logic [23:0] halfway;
        int          hexp;
        int          sh;
        sgn  = x[31];
        sexp = x[30:23];
        mant = {1'b1, x[22:0]};
        if (sexp == 8'hFF)
            return {sgn, 5'h1F, x[22:13]};   // payload truncated, not quieted
        if (sexp == 8'h00)
            return {sgn, 15'd0};
        hexp = int'(sexp) - 112;
        if (hexp >= 31)
            return {sgn, 15'h7C00};
        if (hexp <= 0)
        begin
            sh = 14 - hexp;
            if (sh > 24)
                return {sgn, 15'd0};
            kept    = mant >> sh;
            rem     = mant & ((24'd1 << sh) - 24'd1);
            halfway = 24'd1 << (sh - 1);
            if (rem > halfway || (rem == halfway && kept[0]))
                kept = kept + 24'd1;
            // a carry to 0x400 lands on the smallest normal exponent by itself
            return {sgn, kept[14:0]};
        end
        kept = {14'd0, mant[22:13]};
        rem  = {11'd0, mant[12:0]};
        if (rem > 24'h1000 || (rem == 24'h1000 && kept[0]))
            kept = kept + 24'd1;
        if (kept >= 24'h400)
        begin
            kept = 24'd0;
            hexp = hexp + 1;
            if (hexp >= 31)
                return {sgn, 15'h7C00};
        end
        return {sgn, hexp[4:0], kept[9:0]};
    endfunction

    function automatic logic [31:0] convert_item(input logic [1:0] f,
                                                 input logic [31:0] bits);
        case (f)
            FUNC_H2S: return widen_half(bits[15:0]);
            FUNC_S2H: return {16'd0, narrow_single(bits)};
            FUNC_RT:  return widen_half(narrow_single(bits));
            default:  return 32'd0;
        endcase
    endfunction

    function automatic logic [1:0] pick_func();
        int r;
        r = $urandom_range(15);
        if (r < 5)
            return FUNC_H2S;
        else if (r < 10)
            return FUNC_S2H;
        else if (r < 15)
            return FUNC_RT;
        return FUNC_UNUSED;
    endfunction

    // Operands skewed toward the interesting exponents; the rest stay fully
    // random so every operand bit toggles.
    function automatic logic [31:0] pick_operand(input logic [1:0] f);
        logic [31:0] bits;
        logic [31:0] mask;
        int          style;
        int          sh;
        bits  = $urandom;
        style = $urandom_range(9);
        if (f == FUNC_H2S)
        begin
            if (style < 3)
                bits[14:10] = 5'd0;       // zero and subnormal halves
            else if (style < 5)
                bits[14:10] = 5'h1F;      // infinity and NaN
        end
        else if (style < 6)
        begin
            // exponents spanning underflow, subnormal, normal and overflow
            bits[30:23] = 8'($urandom_range(145, 99));
            if (style < 2)
                bits[12:0] = 13'h1000;    // exact tie for a normal half
        end
        else if (style == 6)
            bits[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
        else if (style == 7)
        begin
            // exact tie at the rounding point of a subnormal half
            bits[30:23] = 8'($urandom_range(112, 103));
            sh   = 126 - int'(bits[30:23]);
            mask = (32'd1 << sh) - 32'd1;
            bits = (bits & ~mask) | (32'd1 << (sh - 1));
        end
        return bits;
    endfunction

    // Hold one transfer on the slave side until the block takes it, then
    // queue what it must answer.
    task automatic send_item(input logic [1:0] f, input logic [31:0] bits,
                             input logic known, input logic [31:0] result);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= bits;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(known ? result : convert_item(f, bits));
        func_count[f]++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
    endtask

    // receiver: back-pressure at the current stall rate
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // scoreboard: every master-side transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("result with nothing pending", 32'hx, m_tdata);
            else
            begin
                oldest_result = expected_results.pop_front();
                if (m_tdata !== oldest_result)
                    report_mismatch("result_bits", oldest_result, m_tdata);
            end
        end
    end

    initial
    begin
        int phase;
        int i;
        logic [1:0] f;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 73;
                end
                1:
                begin
                    send_idle_pct  = 73;
                    recv_stall_pct = 30;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                for (i = 0; i < NUM_DIRECTED; i++)
                    send_item(directed_cases[i].func, directed_cases[i].operand,
                              directed_cases[i].known, directed_cases[i].result);
            end

            repeat (RANDOM_PER_PHASE)
            begin
                f = pick_func();
                send_item(f, pick_operand(f), 1'b0, 32'd0);
            end
        end
        s_tvalid <= 1'b0;

        // drain; the watchdog catches a block that never answers
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d results: %0d widen, %0d narrow, %0d round trip, %0d unused code",
                 results_seen, func_count[FUNC_H2S], func_count[FUNC_S2H],
                 func_count[FUNC_RT], func_count[FUNC_UNUSED]);
        $display("Three idle phases, %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("half_single_float_converter regression: pass");
        else
            $display("half_single_float_converter regression: fail");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #(CLK_PERIOD * 200000);
        $display("Timeout with %0d results still pending", expected_results.size());
        $display("half_single_float_converter regression: fail");
        $finish;
    end

endmodule
